[hdl/ate_pkg.sv]
`default_nettype none
package ate_pkg;

    localparam int MAX_COLUMNS    = 128;
    localparam int MAX_ROWS       = 64;
    localparam int SEQUENCE_LIMIT = 255;

    localparam int CW        = $clog2(MAX_COLUMNS + 1);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int NRW       = $clog2(MAX_ROWS + 1);
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SLW       = $clog2(SEQUENCE_LIMIT + 1);
    localparam int SXW       = 19;

    localparam int COLS_RESET = (80 > MAX_COLUMNS) ? MAX_COLUMNS : 80;
    localparam int ROWS_RESET = (24 > MAX_ROWS) ? MAX_ROWS : 24;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [7:0] C_BEL    = 8'h07;
    localparam logic [7:0] C_BS     = 8'h08;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0a;
    localparam logic [7:0] C_CR     = 8'h0d;
    localparam logic [7:0] C_ESC    = 8'h1b;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_PLUS   = 8'h2b;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_SEMI   = 8'h3b;
    localparam logic [7:0] C_QMARK  = 8'h3f;
    localparam logic [7:0] C_FIN_LO = 8'h40;
    localparam logic [7:0] C_FIN_HI = 8'h7e;
    localparam logic [7:0] C_DEL    = 8'h7f;
    localparam logic [7:0] C_LBRACK = 8'h5b;
    localparam logic [7:0] C_RBRACK = 8'h5d;
    localparam logic [7:0] C_CMD_A  = 8'h41;
    localparam logic [7:0] C_CMD_B  = 8'h42;
    localparam logic [7:0] C_CMD_C  = 8'h43;
    localparam logic [7:0] C_CMD_D  = 8'h44;
    localparam logic [7:0] C_CMD_H  = 8'h48;
    localparam logic [7:0] C_CMD_J  = 8'h4a;
    localparam logic [7:0] C_CMD_K  = 8'h4b;
    localparam logic [7:0] C_CMD_F  = 8'h66;

    typedef enum logic [1:0] {M_NORMAL, M_ESC, M_CSI, M_OSC} t_mode;
    typedef enum logic [1:0] {PH_BETWEEN, PH_BLANKS, PH_DIGITS, PH_DEAD} t_phase;
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_RDWT, S_WALK, S_CHAR, S_DONE
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic latch_in;
        logic exec;
        logic read_cap;
        logic walk_step;
        logic char_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic           clear_last;
        logic           is_read;
        logic           walk_req;
        logic           char_req;
        logic           walk_last;
        logic           char_pend;
        logic [CW-1:0]  cols;
        logic [NRW-1:0] rows;
    } t_sts;

    typedef struct packed {
        logic       we;
        logic       sel;
        logic [7:0] data;
    } t_cfg;

endpackage
`default_nettype wire

[hdl/ansi_text_grid_engine.sv]
`default_nettype none
// Text terminal core with an ANSI/VT100 escape parser. Each input beat is a
// host byte or a grid cell read, and each gives exactly one output beat with
// the cell character (zero for bytes) and the cursor after the step. A
// printable byte or a read passes through accept, execute, grid write or
// registered grid read, and output load; any other byte skips the grid
// write or read. The next beat is taken in the cycle after the output load,
// and the output load waits while the previous output beat is still held. A
// scroll or an erase (ESC[J, ESC[K) adds a walk that blanks one cell a cycle
// through the single write port of the grid memory, up to rows*columns
// cells for a full screen. After reset the grid is filled with spaces by a
// clearing pass over all MAX_ROWS*MAX_COLUMNS (8192) cells, during which no
// beat is accepted; register writes over the APB port are taken at any time
// but must only be issued while the block is idle.
module ansi_text_grid_engine import ate_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_host_byte,
    input  wire logic [5:0]  i_read_row,
    input  wire logic [6:0]  i_read_col,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cursor_col,
    output logic [5:0]       o_cursor_row,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cmd cmd;
    t_sts sts;
    t_cfg cfg;

    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite;
    assign cfg.sel  = paddr[2];
    assign cfg.data = pwdata[7:0];
    assign prdata   = (paddr[2] == REG_ROWS) ? 32'(sts.rows) : 32'(sts.cols);

    ate_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    ate_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_req_type   (i_req_type),
        .i_host_byte  (i_host_byte),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_sts        (sts),
        .o_cell_char  (o_cell_char),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

endmodule
`default_nettype wire

[hdl/ate_ctrl.sv]
`default_nettype none
module ate_ctrl import ate_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.is_read)       n_state = S_RDWT;
                else if (i_sts.walk_req) n_state = S_WALK;
                else if (i_sts.char_req) n_state = S_CHAR;
                else                     n_state = S_DONE;
            end
            S_RDWT: n_state = S_DONE;
            S_WALK: begin
                if (i_sts.walk_last) n_state = i_sts.char_pend ? S_CHAR : S_DONE;
            end
            S_CHAR: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_valid;
            end
            S_EXEC:  o_cmd.exec      = 1'b1;
            S_RDWT:  o_cmd.read_cap  = 1'b1;
            S_WALK:  o_cmd.walk_step = 1'b1;
            S_CHAR:  o_cmd.char_wr   = 1'b1;
            S_DONE:  o_cmd.load_out  = out_free;
            default: o_cmd = '0;
        endcase
        // a loaded beat takes priority over the drain of the previous one
        n_out_valid = o_cmd.load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

endmodule
`default_nettype wire

[hdl/ate_dp.sv]
`default_nettype none
module ate_dp import ate_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_host_byte,
    input  wire logic [5:0] i_read_row,
    input  wire logic [6:0] i_read_col,
    output t_sts            o_sts,
    output logic [7:0]      o_cell_char,
    output logic [7:0]      o_cursor_col,
    output logic [5:0]      o_cursor_row
);

    logic [CW-1:0]  r_cols, n_cols;
    logic [NRW-1:0] r_rows, n_rows;
    logic [RW-1:0]  r_top_off, n_top_off;
    logic [CW-1:0]  r_cur_col, n_cur_col;
    logic [RW-1:0]  r_cur_line, n_cur_line;
    t_mode          r_mode, n_mode;
    logic [SLW-1:0] r_seq_len, n_seq_len;
    logic           r_priv, n_priv;
    logic [15:0]    r_p1, n_p1, r_p2, n_p2;
    logic [1:0]     r_pcnt, n_pcnt;
    t_phase         r_phase, n_phase;
    logic [AW-1:0]  r_clr_addr;

    logic           r_in_type;
    logic [7:0]     r_in_byte;
    logic [5:0]     r_in_row;
    logic [6:0]     r_in_col;

    logic [NRW-1:0] r_wk_row, r_wk_erow;
    logic [CW-1:0]  r_wk_col, r_wk_ecol;
    logic           r_char_pend;
    logic [RW-1:0]  r_wr_row;
    logic [CW-1:0]  r_wr_col;
    logic [7:0]     r_wr_char;

    logic [7:0]     r_mem [MEM_DEPTH];
    logic [7:0]     r_mem_q;
    logic           r_in_range;
    logic [7:0]     r_cell;
    logic [7:0]     r_out_cell;
    logic [CW-1:0]  r_out_col;
    logic [RW-1:0]  r_out_row;

    logic           exec_byte;
    logic           e_walk, e_char;
    logic [NRW-1:0] e_sr, e_er;
    logic [CW-1:0]  e_sc, e_ec;
    logic [RW-1:0]  e_wr_row;
    logic [CW-1:0]  e_wr_col;
    logic           walk_last;
    logic           mem_we;
    logic [AW-1:0]  mem_wa, mem_ra;
    logic [7:0]     mem_wd;
    logic           rd_in_range;

    function automatic logic [AW-1:0] phys(input logic [NRW-1:0] row,
                                           input logic [CW-1:0] col,
                                           input logic [RW-1:0] off,
                                           input logic [NRW-1:0] rows);
        logic [NRW:0] s;
        s = (NRW+1)'(off) + (NRW+1)'(row);
        if (s >= (NRW+1)'(rows)) s = s - (NRW+1)'(rows);
        if (s >= (NRW+1)'(MAX_ROWS)) s = '0;
        return AW'(s) * AW'(MAX_COLUMNS) + AW'(col);
    endfunction

    assign exec_byte = i_cmd.exec && !r_in_type;

    always_comb begin
        logic [7:0]     b;
        logic [NRW-1:0] line_inc;
        logic [NRW-1:0] off_tmp;
        logic [RW-1:0]  off_inc;
        logic           is_digit, is_blank;
        logic [1:0]     fin_cnt;
        logic [15:0]    p0, p1, step, vcur, vnew;
        logic [19:0]    v10;
        t_phase         ph;
        logic [CW:0]    tab;
        logic [SXW-1:0] sx, sy;
        logic [CW-1:0]  last_col, ecol_min, wc;
        logic [RW-1:0]  wl;
        logic           wreq;
        logic [7:0]     cv, rv;

        b        = r_in_byte;
        line_inc = NRW'(r_cur_line) + NRW'(1);
        off_tmp  = NRW'(r_top_off) + NRW'(1);
        off_inc  = (off_tmp >= r_rows) ? '0 : off_tmp[RW-1:0];
        is_digit = (b >= C_ZERO) && (b <= C_NINE);
        is_blank = (b == C_SPACE) || ((b >= C_TAB) && (b <= C_CR));
        last_col = r_cols - CW'(1);
        ecol_min = (r_cur_col < r_cols) ? r_cur_col : last_col;
        fin_cnt  = ((r_phase != PH_BETWEEN) && (r_pcnt < 2'd2)) ? r_pcnt + 2'd1 : r_pcnt;
        p0       = (fin_cnt > 2'd0) ? r_p1 : 16'd0;
        p1       = (fin_cnt > 2'd1) ? r_p2 : 16'd0;
        step     = (p0 > 16'd0) ? p0 : 16'd1;
        vcur     = (r_pcnt == 2'd0) ? r_p1 : r_p2;
        vnew     = vcur;
        ph       = r_phase;
        tab      = '0;
        v10      = '0;
        sx       = SXW'(r_cur_col);
        sy       = SXW'(r_cur_line);
        wc       = r_cur_col;
        wl       = r_cur_line;
        wreq     = 1'b0;
        cv       = '0;
        rv       = '0;

        n_cols     = r_cols;
        n_rows     = r_rows;
        n_top_off  = r_top_off;
        n_cur_col  = r_cur_col;
        n_cur_line = r_cur_line;
        n_mode     = r_mode;
        n_seq_len  = r_seq_len;
        n_priv     = r_priv;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_pcnt     = r_pcnt;
        n_phase    = r_phase;
        e_char     = 1'b0;
        e_wr_row   = r_cur_line;
        e_wr_col   = r_cur_col;
        e_sr       = '0;
        e_sc       = '0;
        e_er       = r_rows - NRW'(1);
        e_ec       = last_col;

        if (exec_byte) begin
            case (r_mode)
                M_NORMAL: begin
                    if (b == C_ESC) begin
                        n_mode = M_ESC;
                    end else if (b == C_LF) begin
                        if (line_inc >= r_rows) begin
                            n_top_off = off_inc;
                            wreq      = 1'b1;
                            e_sr      = r_rows - NRW'(1);
                        end else begin
                            n_cur_line = line_inc[RW-1:0];
                        end
                    end else if (b == C_CR) begin
                        n_cur_col = '0;
                    end else if (b == C_BS) begin
                        if (r_cur_col > '0) n_cur_col = r_cur_col - CW'(1);
                    end else if (b == C_TAB) begin
                        tab = ((CW+1)'(r_cur_col) + (CW+1)'(8)) & ~(CW+1)'(7);
                        n_cur_col = (tab > (CW+1)'(r_cols)) ? r_cols : tab[CW-1:0];
                    end else if ((b >= C_SPACE) && (b <= C_DEL)) begin
                        if (r_cur_col >= r_cols) begin
                            wc = '0;
                            if (line_inc >= r_rows) begin
                                // wrap off the bottom: scroll, stay on the last row
                                n_top_off = off_inc;
                                wreq      = 1'b1;
                                e_sr      = r_rows - NRW'(1);
                            end else begin
                                wl = line_inc[RW-1:0];
                            end
                        end
                        e_char     = 1'b1;
                        e_wr_row   = wl;
                        e_wr_col   = wc;
                        n_cur_col  = wc + CW'(1);
                        n_cur_line = wl;
                    end
                end
                M_ESC: begin
                    if (b == C_LBRACK) begin
                        n_mode    = M_CSI;
                        n_seq_len = '0;
                        n_priv    = 1'b0;
                        n_p1      = '0;
                        n_p2      = '0;
                        n_pcnt    = '0;
                        n_phase   = PH_BETWEEN;
                    end else if (b == C_RBRACK) begin
                        n_mode = M_OSC;
                    end else begin
                        n_mode = M_NORMAL;
                    end
                end
                M_CSI: begin
                    if (r_seq_len < SLW'(SEQUENCE_LIMIT)) begin
                        n_seq_len = r_seq_len + SLW'(1);
                        if ((b >= C_FIN_LO) && (b <= C_FIN_HI)) begin
                            n_mode  = M_NORMAL;
                            n_pcnt  = fin_cnt;
                            n_phase = PH_BETWEEN;
                            if (!r_priv) begin
                                if ((b == C_CMD_H) || (b == C_CMD_F)) begin
                                    sy = (p0 > 16'd0) ? SXW'(p0) - SXW'(1) : '0;
                                    sx = (p1 > 16'd0) ? SXW'(p1) - SXW'(1) : '0;
                                end else if (b == C_CMD_A) begin
                                    sy = sy - SXW'(step);
                                end else if (b == C_CMD_B) begin
                                    sy = sy + SXW'(step);
                                end else if (b == C_CMD_C) begin
                                    sx = sx + SXW'(step);
                                end else if (b == C_CMD_D) begin
                                    sx = sx - SXW'(step);
                                end else if (b == C_CMD_J) begin
                                    if (p0 == 16'd0) begin
                                        wreq = 1'b1;
                                        e_sr = NRW'(r_cur_line);
                                        e_sc = r_cur_col;
                                    end else if (p0 == 16'd1) begin
                                        wreq = 1'b1;
                                        e_er = NRW'(r_cur_line);
                                        e_ec = ecol_min;
                                    end else if ((p0 == 16'd2) || (p0 == 16'd3)) begin
                                        wreq = 1'b1;
                                        sx   = '0;
                                        sy   = '0;
                                    end
                                end else if (b == C_CMD_K) begin
                                    e_sr = NRW'(r_cur_line);
                                    e_er = NRW'(r_cur_line);
                                    if (p0 == 16'd0) begin
                                        wreq = 1'b1;
                                        e_sc = r_cur_col;
                                    end else if (p0 == 16'd1) begin
                                        wreq = 1'b1;
                                        e_ec = ecol_min;
                                    end else if (p0 == 16'd2) begin
                                        wreq = 1'b1;
                                    end
                                end
                                if (sx[SXW-1])                  n_cur_col = '0;
                                else if (sx >= SXW'(r_cols))    n_cur_col = last_col;
                                else                            n_cur_col = sx[CW-1:0];
                                if (sy[SXW-1])                  n_cur_line = '0;
                                else if (sy >= SXW'(r_rows))    n_cur_line = RW'(r_rows - NRW'(1));
                                else                            n_cur_line = sy[RW-1:0];
                            end
                        end else if ((r_seq_len == '0) && (b == C_QMARK)) begin
                            n_priv = 1'b1;
                        end else if (b == C_SEMI) begin
                            n_pcnt  = fin_cnt;
                            n_phase = PH_BETWEEN;
                        end else begin
                            if (ph == PH_BETWEEN) begin
                                ph   = PH_BLANKS;
                                vnew = '0;
                            end
                            if (ph == PH_BLANKS) begin
                                if (is_blank) begin
                                    ph = PH_BLANKS;
                                end else if (b == C_PLUS) begin
                                    ph = PH_DIGITS;
                                end else if (is_digit) begin
                                    ph   = PH_DIGITS;
                                    vnew = 16'(b - C_ZERO);
                                end else begin
                                    ph = PH_DEAD;
                                end
                            end else if (ph == PH_DIGITS) begin
                                if (is_digit) begin
                                    v10  = {vnew, 3'b000} + {3'b000, vnew, 1'b0}
                                         + 20'(b - C_ZERO);
                                    vnew = (v10 > 20'd65535) ? 16'hffff : v10[15:0];
                                end else begin
                                    ph = PH_DEAD;
                                end
                            end
                            n_phase = ph;
                            if (r_pcnt == 2'd0)      n_p1 = vnew;
                            else if (r_pcnt == 2'd1) n_p2 = vnew;
                        end
                    end else begin
                        // overlong: drop the byte and abort
                        n_mode = M_NORMAL;
                    end
                end
                M_OSC: begin
                    if (b == C_BEL)      n_mode = M_NORMAL;
                    else if (b == C_ESC) n_mode = M_ESC;
                end
                default: n_mode = M_NORMAL;
            endcase
        end

        // start past the last column moves to the next row
        if (e_sc >= r_cols) begin
            e_sr = e_sr + NRW'(1);
            e_sc = '0;
        end
        e_walk = wreq && !((e_sr > e_er) || ((e_sr == e_er) && (e_sc > e_ec)));

        if (i_cfg.we) begin
            if (i_cfg.sel == REG_COLS) begin
                cv = i_cfg.data;
                if (cv == 8'd0) cv = 8'd1;
                if (int'(cv) > MAX_COLUMNS) cv = 8'(MAX_COLUMNS);
                n_cols = CW'(cv);
                if (r_cur_col >= n_cols) n_cur_col = n_cols - CW'(1);
            end else begin
                rv = {1'b0, i_cfg.data[6:0]};
                if (rv == 8'd0) rv = 8'd1;
                if (int'(rv) > MAX_ROWS) rv = 8'(MAX_ROWS);
                n_rows    = NRW'(rv);
                n_top_off = '0;
                if (NRW'(r_cur_line) >= n_rows) n_cur_line = RW'(n_rows - NRW'(1));
            end
        end
    end

    assign walk_last   = (r_wk_row == r_wk_erow) && (r_wk_col == r_wk_ecol);
    assign rd_in_range = (int'(r_in_row) < int'(r_rows)) && (int'(r_in_col) < int'(r_cols));
    assign mem_ra      = phys(NRW'(r_in_row), CW'(r_in_col), r_top_off, r_rows);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_addr;
        mem_wd = C_SPACE;
        if (i_cmd.clear_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.walk_step) begin
            mem_we = 1'b1;
            mem_wa = phys(r_wk_row, r_wk_col, r_top_off, r_rows);
        end else if (i_cmd.char_wr) begin
            mem_we = 1'b1;
            mem_wa = phys(NRW'(r_wr_row), r_wr_col, r_top_off, r_rows);
            mem_wd = r_wr_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= CW'(COLS_RESET);
            r_rows      <= NRW'(ROWS_RESET);
            r_top_off   <= '0;
            r_cur_col   <= '0;
            r_cur_line  <= '0;
            r_mode      <= M_NORMAL;
            r_seq_len   <= '0;
            r_priv      <= 1'b0;
            r_p1        <= '0;
            r_p2        <= '0;
            r_pcnt      <= '0;
            r_phase     <= PH_BETWEEN;
            r_clr_addr  <= '0;
            r_char_pend <= 1'b0;
        end else begin
            r_cols     <= n_cols;
            r_rows     <= n_rows;
            r_top_off  <= n_top_off;
            r_cur_col  <= n_cur_col;
            r_cur_line <= n_cur_line;
            r_mode     <= n_mode;
            r_seq_len  <= n_seq_len;
            r_priv     <= n_priv;
            r_p1       <= n_p1;
            r_p2       <= n_p2;
            r_pcnt     <= n_pcnt;
            r_phase    <= n_phase;
            if (i_cmd.clear_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (exec_byte)            r_char_pend <= e_char;
            else if (i_cmd.char_wr)   r_char_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_type <= i_req_type;
            r_in_byte <= i_host_byte;
            r_in_row  <= i_read_row;
            r_in_col  <= i_read_col;
        end
        if (i_cmd.exec) begin
            r_cell     <= '0;
            r_in_range <= rd_in_range;
        end
        if (i_cmd.read_cap) r_cell <= r_in_range ? r_mem_q : 8'd0;
        if (exec_byte) begin
            r_wk_row  <= e_sr;
            r_wk_col  <= e_sc;
            r_wk_erow <= e_er;
            r_wk_ecol <= e_ec;
            r_wr_row  <= e_wr_row;
            r_wr_col  <= e_wr_col;
            r_wr_char <= r_in_byte;
        end else if (i_cmd.walk_step && !walk_last) begin
            if (r_wk_col == r_cols - CW'(1)) begin
                r_wk_row <= r_wk_row + NRW'(1);
                r_wk_col <= '0;
            end else begin
                r_wk_col <= r_wk_col + CW'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_cell <= r_cell;
            r_out_col  <= r_cur_col;
            r_out_row  <= r_cur_line;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clear_last = (r_clr_addr == AW'(MEM_DEPTH - 1));
        o_sts.is_read    = r_in_type;
        o_sts.walk_req   = e_walk;
        o_sts.char_req   = e_char;
        o_sts.walk_last  = walk_last;
        o_sts.char_pend  = r_char_pend;
        o_sts.cols       = r_cols;
        o_sts.rows       = r_rows;
    end

    assign o_cell_char  = r_out_cell;
    assign o_cursor_col = 8'(r_out_col);
    assign o_cursor_row = 6'(r_out_row);

endmodule
`default_nettype wire
